// File: hdl/vssg_pkg.sv
// Shared constants, types and the sequencer microprogram for the voxel shadow block.
`timescale 1ns / 1ps
`default_nettype none

package vssg_pkg;

	localparam int VSSG_VOLUME_SIZE = 64;

	localparam int MODE_W    = 2;
	localparam int COORD_W   = 6;
	localparam int SUM_W     = 13;
	localparam int VAL_W     = 8;
	localparam int NUM_AMT   = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [VAL_W-1:0] VAL_MAX = 8'd255;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_DEPOSIT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GATHER  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

	// amount register reset values, layer 0 first
	localparam logic [VAL_W-1:0] AMOUNT_RST [NUM_AMT] = '{8'd8, 8'd6, 8'd3, 8'd2};
	// stamp half-width per layer
	localparam logic [1:0] LAYER_HALF [NUM_AMT] = '{2'd1, 2'd1, 2'd2, 2'd3};

	typedef logic [3:0] upc_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_JUMP,
		C_DISPATCH,
		C_LOOP,
		C_LAYER,
		C_OUT
	} cond_t;

	typedef enum logic [1:0] {
		B_NONE,
		B_LAYER,
		B_CUBE
	} bsel_t;

	typedef struct packed {
		logic  rd;     // read voxel at the walk position
		logic  wr;     // write back saturated sum
		logic  acc;    // accumulate gather weight
		logic  vlat;   // latch read data as voxel_value
		logic  adv;    // step the x/y/z walk
		logic  nlay;   // step the layer counter
		bsel_t bsel;   // load walk bounds
		cond_t cond;
		upc_t  target;
	} uword_t;

	localparam upc_t S_FETCH   = 4'd0;
	localparam upc_t S_D_SETUP = 4'd1;
	localparam upc_t S_D_READ  = 4'd2;
	localparam upc_t S_D_WRITE = 4'd3;
	localparam upc_t S_D_LAYER = 4'd4;
	localparam upc_t S_FINISH  = 4'd5;
	localparam upc_t S_G_SETUP = 4'd6;
	localparam upc_t S_G_READ  = 4'd7;
	localparam upc_t S_G_ACC   = 4'd8;
	localparam upc_t S_G_DONE  = 4'd9;
	localparam upc_t S_R_READ  = 4'd10;
	localparam upc_t S_R_LATCH = 4'd11;

	function automatic uword_t ucode(input upc_t pc);
		uword_t w;
		w        = '0;
		w.bsel   = B_NONE;
		w.cond   = C_JUMP;
		w.target = S_FETCH;
		case (pc)
			S_FETCH: begin
				w.cond = C_DISPATCH;
			end
			S_D_SETUP: begin
				w.bsel = B_LAYER;
				w.cond = C_NEXT;
			end
			S_D_READ: begin
				w.rd   = 1'b1;
				w.cond = C_NEXT;
			end
			S_D_WRITE: begin
				w.wr     = 1'b1;
				w.adv    = 1'b1;
				w.cond   = C_LOOP;
				w.target = S_D_READ;
			end
			S_D_LAYER: begin
				w.nlay   = 1'b1;
				w.cond   = C_LAYER;
				w.target = S_D_SETUP;
			end
			S_FINISH: begin
				w.cond   = C_OUT;
				w.target = S_FETCH;
			end
			S_G_SETUP: begin
				w.bsel = B_CUBE;
				w.cond = C_NEXT;
			end
			S_G_READ: begin
				w.rd   = 1'b1;
				w.cond = C_NEXT;
			end
			S_G_ACC: begin
				w.acc    = 1'b1;
				w.adv    = 1'b1;
				w.cond   = C_LOOP;
				w.target = S_G_READ;
			end
			S_G_DONE: begin
				w.cond   = C_JUMP;
				w.target = S_FINISH;
			end
			S_R_READ: begin
				w.rd   = 1'b1;
				w.cond = C_NEXT;
			end
			S_R_LATCH: begin
				w.vlat   = 1'b1;
				w.cond   = C_JUMP;
				w.target = S_FINISH;
			end
			default: begin
				w.cond   = C_JUMP;
				w.target = S_FETCH;
			end
		endcase
		return w;
	endfunction

	// entry point of each mode's routine
	function automatic upc_t dispatch(input logic [MODE_W-1:0] mode);
		upc_t pc;
		case (mode)
			MODE_DEPOSIT: pc = S_D_SETUP;
			MODE_GATHER:  pc = S_G_SETUP;
			MODE_READ:    pc = S_R_READ;
			MODE_NONE:    pc = S_FINISH;
			default:      pc = S_FINISH;
		endcase
		return pc;
	endfunction

endpackage

`default_nettype wire

// File: hdl/vssg_in_if.sv
// Input channel: one voxel request word per handshake.
`timescale 1ns / 1ps
`default_nettype none

interface vssg_in_if import vssg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [COORD_W-1:0] x_coord;
	logic [COORD_W-1:0] y_coord;
	logic [COORD_W-1:0] z_coord;

	modport source(output valid, mode, x_coord, y_coord, z_coord, input ready);
	modport sink(input valid, mode, x_coord, y_coord, z_coord, output ready);
endinterface

`default_nettype wire

// File: hdl/vssg_out_if.sv
// Output channel: one result word per handshake.
`timescale 1ns / 1ps
`default_nettype none

interface vssg_out_if import vssg_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [SUM_W-1:0]        weight_sum;
	logic signed [SUM_W-1:0] dir_x;
	logic signed [SUM_W-1:0] dir_y;
	logic signed [SUM_W-1:0] dir_z;
	logic [VAL_W-1:0]        voxel_value;

	modport source(output valid, weight_sum, dir_x, dir_y, dir_z, voxel_value, input ready);
	modport sink(input valid, weight_sum, dir_x, dir_y, dir_z, voxel_value, output ready);
endinterface

`default_nettype wire

// File: hdl/vssg_ram.sv
// Voxel store: simple dual-port RAM, registered read.
`timescale 1ns / 1ps
`default_nettype none

module vssg_ram import vssg_pkg::*; #(
	parameter int AW = 18
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [VAL_W-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [VAL_W-1:0] rdata
);

	logic [VAL_W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/voxel_shadow_stamp_gather.sv
// Voxel shadow volume: deposit stamps, 26-neighbor gather and voxel read.
// One word in flight at a time; a deposit reads then writes back each stamped voxel, layer
//   by layer, a gather reads then accumulates each cube cell, and a read reads then latches;
//   the voxel RAM's single read/write walk sets the pace.
// A result waits in the output register while the next word is taken in.
// Reset: async active low; afterwards a clearing pass zeroes the RAM, one voxel a cycle,
//   with in_ch.ready low; config writes work.
`timescale 1ns / 1ps
`default_nettype none

module voxel_shadow_stamp_gather import vssg_pkg::*; #(
	parameter int VOLUME_SIZE = VSSG_VOLUME_SIZE
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	vssg_in_if.sink                   in_ch,
	vssg_out_if.source                out_ch,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [VAL_W-1:0]     cfg_data
);

	// per-axis address width; RAM address is {z, y, x}
	localparam int AXW = $clog2(VOLUME_SIZE);
	localparam int AW  = 3 * AXW;
	// signed working width for coordinate +/- half-width before clamping
	localparam int CXW = (AXW > COORD_W) ? AXW : COORD_W;
	localparam int SW  = CXW + 2;

	typedef logic [AXW-1:0] ax_t;
	typedef logic signed [SW-1:0] sc_t;

	function automatic ax_t clamp_ax(input sc_t v);
		if (v < 0) begin
			return '0;
		end else if (v > (VOLUME_SIZE - 1)) begin
			return ax_t'(VOLUME_SIZE - 1);
		end else begin
			return ax_t'(v);
		end
	endfunction

	function automatic sc_t ext(input logic [CXW-1:0] u);
		return sc_t'(SW'(u));
	endfunction

	// ---------------------------------------------------------------- control state
	upc_t             upc_q;
	logic [1:0]       k_q;          // stamp layer
	logic             clr_busy_q;
	logic [AW-1:0]    clr_addr_q;
	logic [VAL_W-1:0] amount_q [NUM_AMT];
	logic             out_valid_q;

	// ---------------------------------------------------------------- datapath state
	ax_t              px_q, py_q, pz_q;       // clamped request point
	ax_t              x_q, y_q, z_q;          // walk position
	ax_t              x0_q, x1_q, y0_q, y1_q, z1_q;
	logic [SUM_W-1:0] ws_q, dx_q, dy_q, dz_q;
	logic [VAL_W-1:0] vv_q;
	logic [SUM_W-1:0] ws_o_q, dx_o_q, dy_o_q, dz_o_q;
	logic [VAL_W-1:0] vv_o_q;

	uword_t           uw;
	upc_t             upc_d;
	logic             in_acc;
	logic             out_free;
	logic             last;
	logic             centre;

	ax_t              cx_in, cy_in, cz_in;
	sc_t              px_e, py_e, pz_e;
	sc_t              hs, zoff;
	ax_t              x0_n, x1_n, y0_n, y1_n, zlo_n, zhi_n;

	logic [AW-1:0]    cur_addr;
	logic [VAL_W-1:0] rdata;
	logic [VAL_W:0]   sum9;
	logic [VAL_W-1:0] sat;
	logic [VAL_W-1:0] weight;
	logic [SUM_W-1:0] weight_e;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [VAL_W-1:0] ram_wdata;

	assign uw       = ucode(upc_q);
	assign in_acc   = in_ch.valid & in_ch.ready;
	assign out_free = ~out_valid_q | out_ch.ready;

	assign in_ch.ready = (upc_q == S_FETCH) & ~clr_busy_q;

	// input coordinates clamped into the volume (only bites when the volume is under 64)
	assign cx_in = clamp_ax(ext(CXW'(in_ch.x_coord)));
	assign cy_in = clamp_ax(ext(CXW'(in_ch.y_coord)));
	assign cz_in = clamp_ax(ext(CXW'(in_ch.z_coord)));

	// walk bounds: layer square or the gather cube
	assign px_e  = ext(CXW'(px_q));
	assign py_e  = ext(CXW'(py_q));
	assign pz_e  = ext(CXW'(pz_q));
	assign hs    = (uw.bsel == B_LAYER) ? sc_t'(SW'(LAYER_HALF[k_q])) : sc_t'(1);
	assign zoff  = (uw.bsel == B_LAYER) ? sc_t'(SW'(k_q)) : sc_t'(1);
	assign x0_n  = clamp_ax(px_e - hs);
	assign x1_n  = clamp_ax(px_e + hs);
	assign y0_n  = clamp_ax(py_e - hs);
	assign y1_n  = clamp_ax(py_e + hs);
	assign zlo_n = clamp_ax(pz_e - zoff);
	assign zhi_n = (uw.bsel == B_LAYER) ? zlo_n : clamp_ax(pz_e + sc_t'(1));

	assign last   = (x_q == x1_q) & (y_q == y1_q) & (z_q == z1_q);
	assign centre = (x_q == px_q) & (y_q == py_q) & (z_q == pz_q);

	assign cur_addr = {z_q, y_q, x_q};

	// saturating stamp add
	assign sum9 = {1'b0, rdata} + {1'b0, amount_q[k_q]};
	assign sat  = sum9[VAL_W] ? VAL_MAX : sum9[VAL_W-1:0];

	// gather weight
	assign weight   = VAL_MAX - rdata;
	assign weight_e = SUM_W'(weight);

	// clearing pass owns the write port until it ends; no item runs meanwhile
	assign ram_we    = clr_busy_q | uw.wr;
	assign ram_waddr = clr_busy_q ? clr_addr_q : cur_addr;
	assign ram_wdata = clr_busy_q ? '0 : sat;

	vssg_ram #(
		.AW(AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (uw.rd),
		.raddr(cur_addr),
		.rdata(rdata)
	);

	// next microprogram address
	always_comb begin
		case (uw.cond)
			C_NEXT:     upc_d = upc_q + upc_t'(1);
			C_JUMP:     upc_d = uw.target;
			C_DISPATCH: upc_d = in_acc ? dispatch(in_ch.mode) : upc_q;
			C_LOOP:     upc_d = last ? upc_q + upc_t'(1) : uw.target;
			C_LAYER:    upc_d = (k_q != 2'd3) ? uw.target : upc_q + upc_t'(1);
			C_OUT:      upc_d = out_free ? uw.target : upc_q;
			default:    upc_d = S_FETCH;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= S_FETCH;
			k_q         <= '0;
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_AMT; i++) begin
				amount_q[i] <= AMOUNT_RST[i];
			end
		end else begin
			upc_q <= upc_d;
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (&clr_addr_q) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				amount_q[cfg_index] <= cfg_data;
			end
			if (in_acc) begin
				k_q <= '0;
			end else if (uw.nlay && (k_q != 2'd3)) begin
				k_q <= k_q + 2'd1;
			end
			if (uw.cond == C_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_q <= cx_in;
			py_q <= cy_in;
			pz_q <= cz_in;
			x_q  <= cx_in;
			y_q  <= cy_in;
			z_q  <= cz_in;
			ws_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			dz_q <= '0;
			vv_q <= '0;
		end
		if (uw.bsel != B_NONE) begin
			x0_q <= x0_n;
			x1_q <= x1_n;
			y0_q <= y0_n;
			y1_q <= y1_n;
			z1_q <= zhi_n;
			x_q  <= x0_n;
			y_q  <= y0_n;
			z_q  <= zlo_n;
		end
		// x innermost, then y, then z
		if (uw.adv && !last) begin
			if (x_q != x1_q) begin
				x_q <= x_q + ax_t'(1);
			end else begin
				x_q <= x0_q;
				if (y_q != y1_q) begin
					y_q <= y_q + ax_t'(1);
				end else begin
					y_q <= y0_q;
					z_q <= z_q + ax_t'(1);
				end
			end
		end
		// centre voxel is read but not summed
		if (uw.acc && !centre) begin
			ws_q <= ws_q + weight_e;
			if (x_q > px_q) begin
				dx_q <= dx_q + weight_e;
			end else if (x_q < px_q) begin
				dx_q <= dx_q - weight_e;
			end
			if (y_q > py_q) begin
				dy_q <= dy_q + weight_e;
			end else if (y_q < py_q) begin
				dy_q <= dy_q - weight_e;
			end
			if (z_q > pz_q) begin
				dz_q <= dz_q + weight_e;
			end else if (z_q < pz_q) begin
				dz_q <= dz_q - weight_e;
			end
		end
		if (uw.vlat) begin
			vv_q <= rdata;
		end
		if (uw.cond == C_OUT && out_free) begin
			ws_o_q <= ws_q;
			dx_o_q <= dx_q;
			dy_o_q <= dy_q;
			dz_o_q <= dz_q;
			vv_o_q <= vv_q;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.weight_sum  = ws_o_q;
	assign out_ch.dir_x       = dx_o_q;
	assign out_ch.dir_y       = dy_o_q;
	assign out_ch.dir_z       = dz_o_q;
	assign out_ch.voxel_value = vv_o_q;

endmodule

`default_nettype wire

// File: hdl/vssg_checker.sv
// Port-level checks for the voxel shadow block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module vssg_checker import vssg_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [SUM_W-1:0] weight_sum,
	input wire logic [SUM_W-1:0] dir_x,
	input wire logic [SUM_W-1:0] dir_y,
	input wire logic [SUM_W-1:0] dir_z,
	input wire logic [VAL_W-1:0] voxel_value
);

	// one word in flight: intake closes right after a word is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken twice in a row");

	// no result appears in the cycle right after intake
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result too early");

	// whenever a new result is posted, intake is open in that same cycle
	a_post_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result posted without reopening intake");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(weight_sum) && $stable(dir_x)
			&& $stable(dir_y) && $stable(dir_z) && $stable(voxel_value)))
		else $error("stalled result changed");

endmodule

bind voxel_shadow_stamp_gather vssg_checker u_vssg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.weight_sum (out_ch.weight_sum),
	.dir_x      (out_ch.dir_x),
	.dir_y      (out_ch.dir_y),
	.dir_z      (out_ch.dir_z),
	.voxel_value(out_ch.voxel_value)
);

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the voxel shadow stamp/gather block.
`timescale 1ns / 1ps

module tb_top;
	import vssg_pkg::*;

	localparam int VOL          = VSSG_VOLUME_SIZE;
	localparam int VOL_CELLS    = VOL * VOL * VOL;
	// Room for the clearing pass plus ~1150 words, counting slow deposits, sender gaps
	// and receiver stalls, then about five times over.
	localparam int LIMIT_CYCLES = 3_000_000;
	// The block returns to fetch as soon as its result word is posted, so a short pause is enough.
	localparam int IDLE_PAUSE   = 8;
	localparam int RANDOM_SETS  = 6;
	localparam int WORDS_PER_SET = 188;

	// one request word as it sits on the input channel
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} req_t;

	// one result word
	typedef struct {
		logic [SUM_W-1:0]        weight_sum;
		logic signed [SUM_W-1:0] dir_x;
		logic signed [SUM_W-1:0] dir_y;
		logic signed [SUM_W-1:0] dir_z;
		logic [VAL_W-1:0]        voxel_value;
	} shadow_res_t;

	logic clk;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0]     cfg_data;

	vssg_in_if  in_ch();
	vssg_out_if out_ch();

	voxel_shadow_stamp_gather #(
		.VOLUME_SIZE(VOL)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the volume and of the layer amounts. The volume starts all zero,
	// which is what the block's clearing pass leaves behind.
	bit [VAL_W-1:0]   shadow_vol [VOL_CELLS];
	logic [VAL_W-1:0] amount_cfg [NUM_AMT];

	req_t        pending_words [$];
	shadow_res_t awaited_results [$];
	req_t        cur_req;

	int err_count;
	int results_checked;
	int settings_used;
	int n_deposit, n_gather, n_read, n_none;
	int cyc_count;

	// sender pacing
	int burst_left;
	int gap_left;
	// receiver stall pattern
	bit [31:0] rx_cyc;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int clamp_vol(int v);
		if (v < 0)
			return 0;
		if (v > VOL - 1)
			return VOL - 1;
		return v;
	endfunction

	function automatic int cell_of(int x, int y, int z);
		return (z * VOL + y) * VOL + x;
	endfunction

	// Applies one accepted word to the shadow volume and returns the result word it causes.
	function automatic shadow_res_t shadow_predict(req_t w);
		shadow_res_t r;
		int px, py, pz, lz, h, x, y, z, x0, x1, y0, y1, z0, z1;
		int s, wt, wsum, sx, sy, sz, idx;
		px = clamp_vol(int'(w.x));
		py = clamp_vol(int'(w.y));
		pz = clamp_vol(int'(w.z));
		r.weight_sum  = '0;
		r.dir_x       = '0;
		r.dir_y       = '0;
		r.dir_z       = '0;
		r.voxel_value = '0;
		case (w.mode)
			MODE_DEPOSIT: begin
				// four square layers going down; near the floor they pile onto z = 0
				for (int k = 0; k < NUM_AMT; k++) begin
					h  = int'(LAYER_HALF[k]);
					lz = clamp_vol(pz - k);
					for (y = clamp_vol(py - h); y <= clamp_vol(py + h); y++) begin
						for (x = clamp_vol(px - h); x <= clamp_vol(px + h); x++) begin
							idx = cell_of(x, y, lz);
							s   = shadow_vol[idx] + amount_cfg[k];
							shadow_vol[idx] = (s > 255) ? VAL_MAX : s[VAL_W-1:0];
						end
					end
				end
			end
			MODE_GATHER: begin
				wsum = 0;
				sx   = 0;
				sy   = 0;
				sz   = 0;
				x0 = clamp_vol(px - 1);
				x1 = clamp_vol(px + 1);
				y0 = clamp_vol(py - 1);
				y1 = clamp_vol(py + 1);
				z0 = clamp_vol(pz - 1);
				z1 = clamp_vol(pz + 1);
				for (z = z0; z <= z1; z++) begin
					for (y = y0; y <= y1; y++) begin
						for (x = x0; x <= x1; x++) begin
							if (x != px || y != py || z != pz) begin
								wt   = 255 - shadow_vol[cell_of(x, y, z)];
								wsum += wt;
								sx   += (x - px) * wt;
								sy   += (y - py) * wt;
								sz   += (z - pz) * wt;
							end
						end
					end
				end
				r.weight_sum = wsum[SUM_W-1:0];
				r.dir_x      = sx[SUM_W-1:0];
				r.dir_y      = sy[SUM_W-1:0];
				r.dir_z      = sz[SUM_W-1:0];
			end
			MODE_READ: begin
				r.voxel_value = shadow_vol[cell_of(px, py, pz)];
			end
			default: begin
				// unused mode: volume untouched, all-zero result
			end
		endcase
		return r;
	endfunction

	function automatic void cmp_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endfunction

	function automatic void push_word(logic [MODE_W-1:0] m, int x, int y, int z);
		req_t w;
		w.mode = m;
		w.x    = COORD_W'(x);
		w.y    = COORD_W'(y);
		w.z    = COORD_W'(z);
		pending_words.push_back(w);
		case (m)
			MODE_DEPOSIT: n_deposit++;
			MODE_GATHER:  n_gather++;
			MODE_READ:    n_read++;
			default:      n_none++;
		endcase
	endfunction

	// cluster centers lean toward the faces of the volume so edges get exercised
	function automatic int pick_center();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return VOL - 1;
			default: return int'($urandom_range(0, VOL - 1));
		endcase
	endfunction

	// mostly near the cluster center so deposits and gathers overlap; some anywhere
	function automatic int near(int c);
		if ($urandom_range(0, 4) == 0)
			return int'($urandom_range(0, VOL - 1));
		return clamp_vol(c + int'($urandom_range(0, 6)) - 3);
	endfunction

	// Random words in clusters: repeated deposits around one spot build up (and saturate)
	// counts that later gathers and reads then see.
	task automatic queue_cluster_words(int count);
		int cx, cy, cz, pick;
		logic [MODE_W-1:0] m;
		for (int n = 0; n < count; n++) begin
			if (n % 16 == 0) begin
				cx = pick_center();
				cy = pick_center();
				cz = pick_center();
			end
			pick = int'($urandom_range(0, 99));
			if (pick < 35)
				m = MODE_DEPOSIT;
			else if (pick < 68)
				m = MODE_GATHER;
			else if (pick < 92)
				m = MODE_READ;
			else
				m = MODE_NONE;
			push_word(m, near(cx), near(cy), near(cz));
		end
	endtask

	// Only called while the block is idle; the shadow amounts follow at once.
	task automatic write_amounts(logic [VAL_W-1:0] a0, logic [VAL_W-1:0] a1,
			logic [VAL_W-1:0] a2, logic [VAL_W-1:0] a3);
		logic [VAL_W-1:0] vals [NUM_AMT];
		vals = '{a0, a1, a2, a3};
		for (int k = 0; k < NUM_AMT; k++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(k);
			cfg_data  <= vals[k];
			amount_cfg[k] = vals[k];
			@(posedge clk);
			cfg_we <= 1'b0;
		end
		settings_used++;
	endtask

	// Holds the sender back until every expected word is home, then lets the block settle.
	// Sampled on the falling edge so the clocked processes have all moved.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_ch.valid || awaited_results.size() != 0);
		repeat (IDLE_PAUSE) @(negedge clk);
	endtask

	// Driver: bursts of random length with random gaps between them. A word that is
	// not taken stays on the bus untouched; expectations are formed at acceptance.
	always @(posedge clk or negedge arst_n) begin
		req_t nxt;
		logic nxt_valid;
		if (!arst_n) begin
			in_ch.valid   <= 1'b0;
			in_ch.mode    <= MODE_NONE;
			in_ch.x_coord <= '0;
			in_ch.y_coord <= '0;
			in_ch.z_coord <= '0;
			cur_req    = '0;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				awaited_results.push_back(shadow_predict(cur_req));
			if (!(in_ch.valid && !in_ch.ready)) begin
				nxt       = cur_req;
				nxt_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_words.size() != 0) begin
					nxt       = pending_words.pop_front();
					nxt_valid = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = int'($urandom_range(1, 30));
						// a third of the bursts run straight into the next one
						case ($urandom_range(0, 5))
							0, 1:    gap_left = 0;
							2:       gap_left = int'($urandom_range(20, 60));
							default: gap_left = int'($urandom_range(1, 12));
						endcase
					end
				end
				cur_req = nxt;
				in_ch.valid   <= nxt_valid;
				in_ch.mode    <= nxt.mode;
				in_ch.x_coord <= nxt.x;
				in_ch.y_coord <= nxt.y;
				in_ch.z_coord <= nxt.z;
			end
		end
	end

	// Monitor: checks every accepted result word against the oldest expectation.
	// Ready steps through four phases set by bits 10:9 of a cycle counter: always ready, coin flip,
	// ready only when the low three bits are zero, and stalls while bits 5:4 are both set.
	always @(posedge clk or negedge arst_n) begin
		shadow_res_t want;
		logic rdy;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_cyc = '0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (awaited_results.size() == 0) begin
					$error("result word with nothing expected: weight_sum %0d voxel_value %0d",
						out_ch.weight_sum, out_ch.voxel_value);
					err_count++;
				end else begin
					want = awaited_results.pop_front();
					cmp_field("weight_sum", int'(want.weight_sum), int'(out_ch.weight_sum));
					cmp_field("dir_x", int'(want.dir_x), int'(out_ch.dir_x));
					cmp_field("dir_y", int'(want.dir_y), int'(out_ch.dir_y));
					cmp_field("dir_z", int'(want.dir_z), int'(out_ch.dir_z));
					cmp_field("voxel_value", int'(want.voxel_value), int'(out_ch.voxel_value));
					results_checked++;
				end
			end
			rx_cyc++;
			case (rx_cyc[10:9])
				2'd0:    rdy = 1'b1;
				2'd1:    rdy = 1'($urandom_range(0, 1));
				2'd2:    rdy = (rx_cyc[2:0] == 3'd0);
				default: rdy = (rx_cyc[5:4] != 2'b11);
			endcase
			out_ch.ready <= rdy;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cyc_count++;
		if (cyc_count > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		for (int k = 0; k < NUM_AMT; k++)
			amount_cfg[k] = AMOUNT_RST[k];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset amounts. Fresh volume reads zero; corners gather only 7 neighbors;
		// unused mode; a stamp on the floor piles all four layers onto z = 0;
		// stamps against the top faces clip their squares.
		settings_used = 1;
		push_word(MODE_READ, 0, 0, 0);
		push_word(MODE_GATHER, 0, 0, 0);
		push_word(MODE_GATHER, VOL - 1, VOL - 1, VOL - 1);
		push_word(MODE_NONE, VOL - 1, 0, VOL - 1);
		push_word(MODE_DEPOSIT, 0, 0, 0);
		push_word(MODE_READ, 0, 0, 0);
		push_word(MODE_READ, 3, 3, 0);
		push_word(MODE_GATHER, 1, 1, 1);
		push_word(MODE_DEPOSIT, VOL - 1, VOL - 1, VOL - 1);
		push_word(MODE_DEPOSIT, VOL - 1, 0, 2);
		push_word(MODE_GATHER, VOL - 2, VOL - 2, VOL - 2);
		push_word(MODE_READ, VOL - 1, VOL - 1, VOL - 4);
		push_word(MODE_READ, VOL - 1, 0, 0);
		push_word(MODE_NONE, 0, VOL - 1, 0);
		wait_idle();

		// Full amounts: one stamp fills the whole 3x3x3 cube around (10,10,10) so its
		// gather weighs nothing at all; a second floor stamp saturates the corner.
		write_amounts(8'd255, 8'd255, 8'd255, 8'd255);
		push_word(MODE_DEPOSIT, 10, 10, 12);
		push_word(MODE_GATHER, 10, 10, 10);
		push_word(MODE_READ, 10, 10, 11);
		push_word(MODE_DEPOSIT, 0, 0, 0);
		push_word(MODE_READ, 0, 0, 0);
		push_word(MODE_GATHER, 1, 1, 1);
		wait_idle();

		// Zero amounts: a stamp leaves the volume as it was; untouched spot weighs the most.
		write_amounts(8'd0, 8'd0, 8'd0, 8'd0);
		push_word(MODE_DEPOSIT, 20, 20, 20);
		push_word(MODE_READ, 20, 20, 20);
		push_word(MODE_GATHER, 20, 20, 20);
		wait_idle();

		// Random clusters under several amount settings, draining between settings.
		for (int p = 0; p < RANDOM_SETS; p++) begin
			case (p % 3)
				0: write_amounts(VAL_W'($urandom_range(0, 255)), VAL_W'($urandom_range(0, 255)),
						VAL_W'($urandom_range(0, 255)), VAL_W'($urandom_range(0, 255)));
				1: write_amounts(8'd255, 8'd0, 8'd255, 8'd0);
				default: write_amounts(8'd0, 8'd255, 8'd1, 8'd128);
			endcase
			queue_cluster_words(WORDS_PER_SET);
			wait_idle();
		end

		$display("tb: %0d deposits, %0d gathers, %0d reads, %0d unused-mode words",
			n_deposit, n_gather, n_read, n_none);
		$display("tb: %0d result words checked over %0d amount settings, %0d mismatches",
			results_checked, settings_used, err_count);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: filelist.f
hdl/vssg_pkg.sv
hdl/vssg_in_if.sv
hdl/vssg_out_if.sv
hdl/vssg_ram.sv
hdl/voxel_shadow_stamp_gather.sv
hdl/vssg_checker.sv
dv/tb_top.sv
